@@ hw/rtl/lfla_pkg.sv @@
// ----------------------------------------------------------------------------
// lfla_pkg
// Shared types, codes and fixed-point helpers of the limited flux line
// advection block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfla_pkg;

  localparam int DEF_CELLS     = 32;
  localparam int DEF_FRAC_BITS = 16;

  // bit-serial divider geometry
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CNT_W  = 7;

  localparam logic [30:0] FLOOR_RESET = 31'd65536;
  localparam logic [30:0] POS_MAX     = 31'h7FFF_FFFF;

  typedef enum logic {
    MODE_FACE = 1'b0,
    MODE_CELL = 1'b1
  } mode_e;

  typedef enum logic {
    CFG_DT    = 1'b0,
    CFG_FLOOR = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [30:0] dt;
    logic [30:0] floor;
  } lfla_cfg_t;

  typedef struct packed {
    logic signed [31:0] accel;
    logic signed [31:0] speed;
    logic signed [31:0] fscale;
    logic [30:0]        weight;
    logic [30:0]        inv_weight;
  } lfla_line_t;

  typedef struct packed {
    logic               cell_we;
    logic               face_we;
    logic [5:0]         index;
    logic signed [31:0] value;
  } lfla_wr_t;

  typedef struct packed {
    logic [4:0]  cell_index;
    logic [30:0] new_value;
    logic        last;
  } lfla_res_t;

  // one entry of the per-cell memory
  typedef struct packed {
    logic signed [31:0] val;
    logic [30:0]        mass;
    logic signed [33:0] newm;
    logic [30:0]        outg;
  } lfla_cell_t;

  // one entry of the per-face memory
  typedef struct packed {
    logic signed [31:0] factor;
    logic signed [31:0] flux;
  } lfla_face_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_M_RD, S_M_MUL, S_M_WR,
    S_F_RD, S_F_MUL, S_F_DST, S_F_DIV,
    S_F_C0, S_F_C1, S_F_C2, S_F_FV,
    S_F_MUL1, S_F_MUL2, S_F_MUL3, S_F_ACC,
    S_U_RD, S_U_CHK, S_U_SCL, S_U_DIV,
    S_U_MUL, S_U_MUL2, S_U_L, S_U_R,
    S_O_RD, S_O_MUL, S_O_EMIT
  } lfla_state_e;

  // signed value from sign and magnitude, saturated to 32 bits
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic signed [31:0] r;
    if (neg) begin
      r = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - mag);
    end else begin
      r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  // fixed-point product post-processing: truncate magnitude, saturate
  function automatic logic signed [31:0] mulq_post(input logic signed [63:0] p,
                                                   input int frac);
    logic [63:0] mag;
    mag = p[63] ? 64'(-p) : 64'(p);
    mag = mag >> frac;
    return sat_mag(p[63], mag);
  endfunction

  // negative cell values read as zero
  function automatic logic [30:0] cell_val(input logic signed [31:0] v);
    return v[31] ? 31'd0 : v[30:0];
  endfunction

  function automatic logic [30:0] satpos34(input logic signed [33:0] v);
    logic [30:0] r;
    if (v[33]) r = 31'd0;
    else if (|v[32:31]) r = POS_MAX;
    else r = v[30:0];
    return r;
  endfunction

  function automatic logic [30:0] satpos36(input logic signed [35:0] v);
    logic [30:0] r;
    if (v[35]) r = 31'd0;
    else if (|v[34:31]) r = POS_MAX;
    else r = v[30:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/limited_flux_line_advection_top.sv @@
// A load item is accepted whenever the block is not busy; after the last_cell transfer the line
// runs a mass pass, a flux pass, a limiting and update pass and an output pass that hands off
// one result at a time. Throughput is set by the bit-serial divider, used once per face to divide
// by the speed and once per nonzero-flux face whose donor is limited, and by the cell memory read port.
// Input is stalled from the start of the line run until its last result is handed off.
// Reset clears control state, configuration and line scalars; memories are not cleared.
// ----------------------------------------------------------------------------
// limited_flux_line_advection_top
// Configuration, input decode, line scalar latch and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module limited_flux_line_advection_top
  import lfla_pkg::*;
#(
  parameter int CELLS     = DEF_CELLS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mode_i,
  input  wire logic [5:0]         index_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic signed [31:0] line_accel_i,
  input  wire logic signed [31:0] line_speed_i,
  input  wire logic signed [31:0] line_flux_scale_i,
  input  wire logic [30:0]        line_weight_i,
  input  wire logic [30:0]        line_inv_weight_i,
  input  wire logic               last_cell_i,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [4:0]              cell_index_o,
  output logic [30:0]             new_value_o,
  output logic                    last_o
);

  lfla_cfg_t  cfg_q;
  lfla_line_t line_q;
  lfla_wr_t   wr;
  lfla_res_t  res, res_q;
  logic       in_xfer, start, busy, res_valid, res_ready, out_valid_q;

  assign in_xfer    = in_valid && !in_stall;
  assign in_stall   = busy;
  assign cfg_ready  = 1'b1;

  // input decode
  always_comb begin
    wr.index   = index_i;
    wr.value   = value_i;
    wr.cell_we = in_xfer && (mode_i == MODE_CELL) && ({1'b0, index_i} < 7'(CELLS));
    wr.face_we = in_xfer && (mode_i == MODE_FACE) && ({1'b0, index_i} <= 7'(CELLS));
  end
  assign start = in_xfer && (mode_i == MODE_CELL) && last_cell_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dt    <= '0;
      cfg_q.floor <= FLOOR_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_DT:    cfg_q.dt    <= cfg_data_i[30:0];
        CFG_FLOOR: cfg_q.floor <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // line scalars latched with cell 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else if (wr.cell_we && (index_i == '0)) begin
      line_q.accel      <= line_accel_i;
      line_q.speed      <= line_speed_i;
      line_q.fscale     <= line_flux_scale_i;
      line_q.weight     <= line_weight_i;
      line_q.inv_weight <= line_inv_weight_i;
    end
  end

  lfla_engine #(
    .CELLS     (CELLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .start_i     (start),
    .cfg_i       (cfg_q),
    .line_i      (line_q),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || !out_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) res_q <= res;
  end

  assign out_valid    = out_valid_q;
  assign cell_index_o = res_q.cell_index;
  assign new_value_o  = res_q.new_value;
  assign last_o       = res_q.last;

endmodule

`default_nettype wire

@@ hw/rtl/lfla_div.sv @@
// ----------------------------------------------------------------------------
// lfla_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfla_div
  import lfla_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic      [DIVIDEND_W-1:0] quotient_o,
  output logic                       done_o
);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    rem_sh;

  // one shift-subtract step per cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = DIV_CNT_W'(DIVIDEND_W);
    end else if (cnt_q != '0) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = DIVISOR_W'(rem_sh - {1'b0, dvs_q});
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIVISOR_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

@@ hw/rtl/lfla_engine.sv @@
// ----------------------------------------------------------------------------
// lfla_engine
// Cell and face memories with the sequencer that runs the line substep.
// ----------------------------------------------------------------------------
`default_nettype none

module lfla_engine
  import lfla_pkg::*;
#(
  parameter int CELLS     = DEF_CELLS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire lfla_wr_t   wr_i,
  input  wire logic       start_i,
  input  wire lfla_cfg_t  cfg_i,
  input  wire lfla_line_t line_i,
  output logic            busy_o,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output lfla_res_t       res_o
);

  localparam int CW = $clog2(CELLS);
  localparam int FW = $clog2(CELLS + 1);

  lfla_state_e state_q, state_d;

  // memories
  lfla_cell_t cell_mem [CELLS];
  lfla_face_t face_mem [CELLS+1];
  lfla_cell_t cell_rd_q, cell_wd;
  lfla_face_t face_rd_q, face_wd;
  logic [CW-1:0] cell_raddr, cell_waddr;
  logic [FW-1:0] face_raddr, face_waddr;
  logic we_val, we_mass, we_newm, we_outg, we_factor, we_flux;

  // datapath registers
  logic [FW-1:0]          cnt_q, cnt_d;
  logic signed [63:0]     prod_q, prod_d;
  logic signed [31:0]     mul_a, mul_b;
  logic                   mul_en;
  logic signed [31:0]     rate_q, rate_d;
  logic [CW-1:0]          base_q, base_d;
  logic [30:0]            cm_q, cm_d, cc_q, cc_d, fv_q, fv_d;
  logic signed [31:0]     ff_q, ff_d;
  logic [CW-1:0]          donor_q, donor_d;
  logic [FRAC_BITS:0]     scl_q, scl_d;

  // divider hookup
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;

  // helpers
  logic                  cnt_last;
  logic [CW-1:0]         f_cell, f_prev;
  logic signed [31:0]    post, flr, ueff;
  logic [CW-1:0]         lo_addr, hi_addr;
  logic                  need_div;

  assign cnt_last = (cnt_q == FW'(CELLS - 1));
  assign f_cell   = cnt_q[CW-1:0];
  assign f_prev   = CW'(cnt_q - FW'(1));
  assign post     = mulq_post(prod_q, FRAC_BITS);
  assign flr      = (cfg_i.floor == '0) ? 32'sd1 : $signed({1'b0, cfg_i.floor});
  assign ueff     = (line_i.speed > flr) ? line_i.speed : flr;
  assign lo_addr  = (base_q == '0) ? base_q : base_q - CW'(1);
  assign hi_addr  = (base_q == CW'(CELLS - 1)) ? base_q : base_q + CW'(1);
  assign need_div = (cell_rd_q.outg > cell_rd_q.mass);

  lfla_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .done_o     (div_done)
  );

  // limited slope and upwind face value
  logic signed [32:0] dl, dr;
  logic signed [33:0] ssum;
  logic [33:0]        smag, amag, bmag, mmag;
  logic [32:0]        hmag;
  logic signed [35:0] hs, fv_full;
  logic [30:0]        cp;
  logic               same_sign, end_cell;

  always_comb begin
    cp        = cell_val(cell_rd_q.val);
    dl        = $signed({2'b00, cc_q}) - $signed({2'b00, cm_q});
    dr        = $signed({2'b00, cp}) - $signed({2'b00, cc_q});
    same_sign = (dl > 0 && dr > 0) || (dl < 0 && dr < 0);
    end_cell  = (base_q == '0) || (base_q == CW'(CELLS - 1));
    ssum      = 34'(dl) + 34'(dr);
    smag      = ssum[33] ? 34'(-ssum) : 34'(ssum);
    smag      = smag >> 1;
    amag      = 34'(dl[32] ? -dl : dl) << 1;
    bmag      = 34'(dr[32] ? -dr : dr) << 1;
    mmag      = smag;
    if (amag < mmag) mmag = amag;
    if (bmag < mmag) mmag = bmag;
    hmag      = 33'(mmag >> 1);
    if (!same_sign || end_cell) hmag = '0;
    hs        = ssum[33] ? -$signed({3'b000, hmag}) : $signed({3'b000, hmag});
    fv_full   = rate_q[31] ? $signed({5'b0, cc_q}) - hs : $signed({5'b0, cc_q}) + hs;
    fv_d      = satpos36(fv_full);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start_i) state_d = S_M_RD;
      S_M_RD:   state_d = S_M_MUL;
      S_M_MUL:  state_d = S_M_WR;
      S_M_WR:   state_d = cnt_last ? S_F_RD : S_M_RD;
      S_F_RD:   state_d = S_F_MUL;
      S_F_MUL:  state_d = S_F_DST;
      S_F_DST:  state_d = S_F_DIV;
      S_F_DIV:  if (div_done) state_d = S_F_C0;
      S_F_C0:   state_d = S_F_C1;
      S_F_C1:   state_d = S_F_C2;
      S_F_C2:   state_d = S_F_FV;
      S_F_FV:   state_d = S_F_MUL1;
      S_F_MUL1: state_d = S_F_MUL2;
      S_F_MUL2: state_d = S_F_MUL3;
      S_F_MUL3: state_d = S_F_ACC;
      S_F_ACC:  state_d = cnt_last ? S_U_RD : S_F_RD;
      S_U_RD:   state_d = S_U_CHK;
      S_U_CHK: begin
        if (face_rd_q.flux != '0) state_d = S_U_SCL;
        else state_d = cnt_last ? S_O_RD : S_U_RD;
      end
      S_U_SCL:  state_d = need_div ? S_U_DIV : S_U_MUL;
      S_U_DIV:  if (div_done) state_d = S_U_MUL;
      S_U_MUL:  state_d = S_U_MUL2;
      S_U_MUL2: state_d = S_U_L;
      S_U_L:    state_d = S_U_R;
      S_U_R:    state_d = cnt_last ? S_O_RD : S_U_RD;
      S_O_RD:   state_d = S_O_MUL;
      S_O_MUL:  state_d = S_O_EMIT;
      S_O_EMIT: if (res_ready_i) state_d = cnt_last ? S_IDLE : S_O_RD;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs, memory accesses and datapath updates
  always_comb begin
    logic signed [31:0] flux;
    logic [30:0]        fmag;
    logic [31:0]        acc;
    logic [30:0]        m;
    cell_raddr   = f_cell;
    face_raddr   = cnt_q;
    cell_waddr   = f_cell;
    face_waddr   = cnt_q;
    cell_wd      = cell_rd_q;
    face_wd      = face_rd_q;
    we_val       = 1'b0;
    we_mass      = 1'b0;
    we_newm      = 1'b0;
    we_outg      = 1'b0;
    we_factor    = 1'b0;
    we_flux      = 1'b0;
    cnt_d        = cnt_q;
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    rate_d       = rate_q;
    base_d       = base_q;
    cm_d         = cm_q;
    cc_d         = cc_q;
    ff_d         = ff_q;
    donor_d      = donor_q;
    scl_d        = scl_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DIVISOR_W'(ueff);
    res_valid_o  = 1'b0;
    res_o        = '0;
    flux         = post;
    fmag         = '0;
    acc          = '0;
    m            = '0;
    case (state_q)
      S_IDLE: begin
        cell_waddr     = CW'(wr_i.index);
        face_waddr     = FW'(wr_i.index);
        cell_wd.val    = wr_i.value;
        face_wd.factor = wr_i.value;
        we_val         = wr_i.cell_we;
        we_factor      = wr_i.face_we;
        if (start_i) cnt_d = '0;
      end
      // mass pass
      S_M_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, cell_val(cell_rd_q.val)});
        mul_b  = $signed({1'b0, line_i.weight});
      end
      S_M_WR: begin
        m            = post[31] ? 31'd0 : post[30:0];
        cell_wd.mass = m;
        cell_wd.newm = $signed({3'b000, m});
        cell_wd.outg = '0;
        we_mass      = 1'b1;
        we_newm      = 1'b1;
        we_outg      = 1'b1;
        cnt_d        = cnt_last ? FW'(1) : cnt_q + FW'(1);
      end
      // flux pass
      S_F_MUL: begin
        mul_en = 1'b1;
        mul_a  = line_i.accel;
        mul_b  = face_rd_q.factor;
      end
      S_F_DST: begin
        div_start    = 1'b1;
        div_dividend = prod_q[63] ? DIVIDEND_W'(-prod_q) : DIVIDEND_W'(prod_q);
      end
      S_F_DIV: begin
        if (div_done) begin
          rate_d = sat_mag(prod_q[63], div_quotient);
          base_d = rate_d[31] ? f_cell : f_prev;
        end
      end
      S_F_C0: cell_raddr = lo_addr;
      S_F_C1: begin
        cell_raddr = base_q;
        cm_d       = cell_val(cell_rd_q.val);
      end
      S_F_C2: begin
        cell_raddr = hi_addr;
        cc_d       = cell_val(cell_rd_q.val);
      end
      S_F_MUL1: begin
        mul_en = 1'b1;
        mul_a  = line_i.fscale;
        mul_b  = rate_q;
      end
      S_F_MUL2: begin
        mul_en = 1'b1;
        mul_a  = post;
        mul_b  = $signed({1'b0, fv_q});
      end
      S_F_MUL3: begin
        flux         = post;
        face_wd.flux = flux;
        we_flux      = 1'b1;
        if (flux[31]) fmag = (flux == 32'sh8000_0000) ? POS_MAX : 31'(-flux);
        else fmag = flux[30:0];
        mul_en       = 1'b1;
        mul_a        = $signed({1'b0, cfg_i.dt});
        mul_b        = $signed({1'b0, fmag});
        donor_d      = flux[31] ? f_cell : f_prev;
        cell_raddr   = donor_d;
      end
      S_F_ACC: begin
        acc          = 32'(cell_rd_q.outg) + 32'(post[30:0]);
        cell_waddr   = donor_q;
        cell_wd.outg = acc[31] ? POS_MAX : acc[30:0];
        we_outg      = 1'b1;
        cnt_d        = cnt_last ? FW'(1) : cnt_q + FW'(1);
      end
      // limiting and update pass
      S_U_CHK: begin
        ff_d = face_rd_q.flux;
        if (face_rd_q.flux == '0) begin
          cnt_d = cnt_last ? '0 : cnt_q + FW'(1);
        end else begin
          donor_d    = face_rd_q.flux[31] ? f_cell : f_prev;
          cell_raddr = donor_d;
        end
      end
      S_U_SCL: begin
        div_dividend = DIVIDEND_W'(cell_rd_q.mass) << FRAC_BITS;
        div_divisor  = DIVISOR_W'(cell_rd_q.outg);
        if (need_div) div_start = 1'b1;
        else scl_d = {1'b1, FRAC_BITS'(0)};
      end
      S_U_DIV: if (div_done) scl_d = div_quotient[FRAC_BITS:0];
      S_U_MUL: begin
        mul_en = 1'b1;
        mul_a  = ff_q;
        mul_b  = $signed(32'(scl_q));
      end
      S_U_MUL2: begin
        mul_en     = 1'b1;
        mul_a      = $signed({1'b0, cfg_i.dt});
        mul_b      = post;
        cell_raddr = f_prev;
      end
      S_U_L: begin
        cell_waddr   = f_prev;
        cell_wd.newm = cell_rd_q.newm - 34'(post);
        we_newm      = 1'b1;
        cell_raddr   = f_cell;
      end
      S_U_R: begin
        cell_wd.newm = cell_rd_q.newm + 34'(post);
        we_newm      = 1'b1;
        cnt_d        = cnt_last ? '0 : cnt_q + FW'(1);
      end
      // output pass
      S_O_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, satpos34(cell_rd_q.newm)});
        mul_b  = $signed({1'b0, line_i.inv_weight});
      end
      S_O_EMIT: begin
        res_valid_o      = 1'b1;
        res_o.cell_index = 5'(cnt_q);
        res_o.new_value  = post[31] ? 31'd0 : post[30:0];
        res_o.last       = cnt_last;
        if (res_ready_i) cnt_d = cnt_q + FW'(1);
      end
      default: ;
    endcase
  end

  // shared multiplier, registered
  assign prod_d = mul_en ? mul_a * mul_b : prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    rate_q  <= rate_d;
    base_q  <= base_d;
    cm_q    <= cm_d;
    cc_q    <= cc_d;
    fv_q    <= (state_q == S_F_FV) ? fv_d : fv_q;
    ff_q    <= ff_d;
    donor_q <= donor_d;
    scl_q   <= scl_d;
  end

  // cell memory, field write enables, registered read
  always_ff @(posedge clk_i) begin
    if (we_val)  cell_mem[cell_waddr].val  <= cell_wd.val;
    if (we_mass) cell_mem[cell_waddr].mass <= cell_wd.mass;
    if (we_newm) cell_mem[cell_waddr].newm <= cell_wd.newm;
    if (we_outg) cell_mem[cell_waddr].outg <= cell_wd.outg;
    cell_rd_q <= cell_mem[cell_raddr];
  end

  // face memory
  always_ff @(posedge clk_i) begin
    if (we_factor) face_mem[face_waddr].factor <= face_wd.factor;
    if (we_flux)   face_mem[face_waddr].flux   <= face_wd.flux;
    face_rd_q <= face_mem[face_raddr];
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/lfla_checker.sv @@
// ----------------------------------------------------------------------------
// lfla_checker
// Port-level checks of the limited flux line advection block.
// ----------------------------------------------------------------------------
`default_nettype none

module lfla_checker
  import lfla_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic mode_i,
  input wire logic last_cell_i,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic last_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a line start blocks further input
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall && (mode_i == MODE_CELL) && last_cell_i |=> in_stall)
    else $error("input accepted right after line start");

  // a result before the last one means the line is still running
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !last_o |-> in_stall)
    else $error("input open while line results pending");

endmodule

bind limited_flux_line_advection_top lfla_checker u_lfla_checker (.*);

`default_nettype wire

@@ tb/limited_flux_line_advection_top_tb.sv @@
// ----------------------------------------------------------------------------
// limited_flux_line_advection_top_tb
// Loads face factors and cell lines into the advection block and checks every
// updated cell value against an in-bench fixed-point model of the substep.
// Both sides idle and stall at random but for the last phase; the configuration is changed between
// phases once all updated values have come back.
// ----------------------------------------------------------------------------
`default_nettype none

module limited_flux_line_advection_top_tb
  import lfla_pkg::*;
();

  localparam int  NCELL    = 32;
  localparam int  FB       = 16;
  localparam longint QMAX  = 64'sd2147483647;
  localparam longint QMIN  = -64'sd2147483648;
  localparam int  ONE      = 1 << FB;

  // substep predictor and store of expected cell updates
  class line_update_board;
    int      cells[NCELL];
    int      factors[NCELL+1];
    int      accel, speed, fscale, weight, inv_weight;
    longint  dt, floor_q;
    lfla_res_t expected_cells[$];
    int      mismatches;
    int      checked;
    int      lines;

    function new();
      dt = 0;
      floor_q = 65536;
    endfunction

    function void set_reg(cfg_reg_e r, logic [31:0] d);
      if (r == CFG_DT) dt = d[30:0];
      else floor_q = d[30:0];
    endfunction

    function longint sat32(longint v);
      return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
    endfunction

    function longint satpos(longint v);
      return v < 0 ? 0 : (v > QMAX ? QMAX : v);
    endfunction

    // exact product, magnitude truncated, saturated
    function longint qmul(longint a, longint b);
      longint p, m;
      p = sat32(a) * sat32(b);
      m = p < 0 ? -p : p;
      m = m >> FB;
      return sat32(p < 0 ? -m : m);
    endfunction

    function longint cval(int c);
      return cells[c] < 0 ? 0 : cells[c];
    endfunction

    // monotonized-central slope, zero at the end cells
    function longint mc_slope(int c);
      longint dl, dr, s, mag, a, b;
      if (c <= 0 || c >= NCELL - 1) return 0;
      dl = cval(c) - cval(c - 1);
      dr = cval(c + 1) - cval(c);
      if (!((dl > 0 && dr > 0) || (dl < 0 && dr < 0))) return 0;
      s = dl + dr;
      mag = (s < 0 ? -s : s) >> 1;
      a = 2 * (dl < 0 ? -dl : dl);
      b = 2 * (dr < 0 ? -dr : dr);
      if (a < mag) mag = a;
      if (b < mag) mag = b;
      return s < 0 ? -mag : mag;
    endfunction

    function longint halve(longint s);
      return s < 0 ? -((-s) >> 1) : (s >> 1);
    endfunction

    function void run_substep();
      longint flr, ueff, rate, fv, fl, mag, acc, o, m, d, v;
      longint mass[NCELL], newm[NCELL], outg[NCELL], scl[NCELL];
      longint flux[NCELL+1];
      int donor;
      lfla_res_t r;
      flr  = floor_q != 0 ? floor_q : 1;
      ueff = speed > flr ? speed : flr;
      for (int i = 0; i < NCELL; i++) begin
        mass[i] = satpos(qmul(cval(i), weight));
        newm[i] = mass[i];
        outg[i] = 0;
      end
      // face fluxes and donor outflow sums
      for (int f = 1; f < NCELL; f++) begin
        rate = sat32((longint'(accel) * longint'(factors[f])) / ueff);
        if (rate >= 0) fv = cval(f - 1) + halve(mc_slope(f - 1));
        else fv = cval(f) - halve(mc_slope(f));
        fv = satpos(fv);
        fl = qmul(qmul(fscale, rate), fv);
        flux[f] = fl;
        donor = fl >= 0 ? f - 1 : f;
        mag = fl < 0 ? -fl : fl;
        acc = outg[donor] + qmul(dt, mag);
        outg[donor] = acc > QMAX ? QMAX : acc;
      end
      // positivity limiter per donor
      for (int i = 0; i < NCELL; i++) begin
        o = outg[i];
        m = mass[i];
        scl[i] = ONE;
        if (o > m && o > 0) scl[i] = (m << FB) / o;
      end
      for (int f = 1; f < NCELL; f++) begin
        if (flux[f] != 0) begin
          donor = flux[f] >= 0 ? f - 1 : f;
          d = qmul(dt, qmul(flux[f], scl[donor]));
          newm[f - 1] -= d;
          newm[f] += d;
        end
      end
      for (int i = 0; i < NCELL; i++) begin
        v = satpos(qmul(satpos(newm[i]), inv_weight));
        r.cell_index = i[4:0];
        r.new_value  = v[30:0];
        r.last       = (i == NCELL - 1);
        expected_cells.push_back(r);
      end
      lines++;
    endfunction

    // accepted input transfer
    function void note_item(mode_e md, logic [5:0] idx, int val, int acc, int spd,
                            int fs, logic [30:0] w, logic [30:0] iw, logic lc);
      if (md == MODE_FACE) begin
        if (idx <= NCELL) factors[idx] = val;
        return;
      end
      if (idx < NCELL) begin
        cells[idx] = val;
        if (idx == 0) begin
          accel = acc; speed = spd; fscale = fs;
          weight = w; inv_weight = iw;
        end
      end
      if (lc) run_substep();
    endfunction

    // accepted output transfer
    function void check_result(lfla_res_t got);
      lfla_res_t exp_r;
      checked++;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: cell %0d value %0d last %0b",
                   got.cell_index, got.new_value, got.last);
        return;
      end
      exp_r = expected_cells.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp cell %0d value %0d last %0b, got cell %0d value %0d last %0b",
                   exp_r.cell_index, exp_r.new_value, exp_r.last,
                   got.cell_index, got.new_value, got.last);
      end
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_reg_e           cfg_index_i = CFG_DT;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mode_e              mode_i = MODE_FACE;
  logic [5:0]         index_i = '0;
  logic signed [31:0] value_i = '0;
  logic signed [31:0] line_accel_i = '0;
  logic signed [31:0] line_speed_i = '0;
  logic signed [31:0] line_flux_scale_i = '0;
  logic [30:0]        line_weight_i = '0;
  logic [30:0]        line_inv_weight_i = '0;
  logic               last_cell_i = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         cell_index_o;
  logic [30:0]        new_value_o;
  logic               last_o;

  line_update_board board = new();
  int snd_idle = 26;
  int rcv_idle = 53;
  int items_sent = 0;
  int cfg_writes = 0;

  limited_flux_line_advection_top i_dut (
    .clk_i, .rst_ni, .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i,
    .in_valid, .in_stall, .mode_i, .index_i, .value_i, .line_accel_i,
    .line_speed_i, .line_flux_scale_i, .line_weight_i, .line_inv_weight_i,
    .last_cell_i, .out_valid, .out_stall, .cell_index_o, .new_value_o, .last_o
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall
  always @(negedge clk_i) begin
    out_stall = ($urandom_range(99) < rcv_idle);
  end

  // result transfer check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      board.check_result('{cell_index: cell_index_o, new_value: new_value_o, last: last_o});
  end

  // run limit
  initial begin
    #40_000_000;
    $display("limited_flux_line_advection_top_tb NOT OK");
    $finish;
  end

  // one input transfer; returns at a falling edge with valid still high
  task automatic send_item(mode_e md, logic [5:0] idx, int val, int acc, int spd, int fs,
                           logic [30:0] w, logic [30:0] iw, logic lc);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    mode_i = md; index_i = idx; value_i = val;
    line_accel_i = acc; line_speed_i = spd; line_flux_scale_i = fs;
    line_weight_i = w; line_inv_weight_i = iw; last_cell_i = lc;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    board.note_item(md, idx, val, acc, spd, fs, w, iw, lc);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [31:0] d);
    in_valid = 1'b0;
    cfg_valid = 1'b1; cfg_index_i = r; cfg_data_i = d;
    do @(posedge clk_i); while (!cfg_ready);
    board.set_reg(r, d);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // hold the sender until every expected update has come back
  task automatic drain();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic int rnd_q(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // cell values: mostly moderate positive, some negative and extreme
  function automatic int rnd_cell();
    case ($urandom_range(9))
      0: return $urandom();
      1: return rnd_q(ONE);
      2: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 16 * ONE);
    endcase
  endfunction

  function automatic int rnd_factor();
    if ($urandom_range(7) == 0) return $urandom();
    return rnd_q(4 * ONE);
  endfunction

  // a well-formed line: a few face updates, then cells 0..31 with last on 31
  task automatic send_line();
    int acc, spd, fs, n;
    logic [30:0] w, iw;
    bit full;
    full = ($urandom_range(5) == 0);
    n = $urandom_range(0, 4);
    for (int k = 0; k < n; k++)
      send_item(MODE_FACE, 6'($urandom_range(0, NCELL)), rnd_factor(), $urandom(), $urandom(),
                $urandom(), 31'($urandom()), 31'($urandom()), 1'($urandom_range(1)));
    acc = full ? $urandom() : rnd_q(4 * ONE);
    spd = full ? $urandom() : $urandom_range(0, 4 * ONE);
    fs  = full ? $urandom() : rnd_q(2 * ONE);
    w   = full ? 31'($urandom()) : 31'($urandom_range(0, 4 * ONE));
    iw  = full ? 31'($urandom()) : 31'($urandom_range(0, 4 * ONE));
    for (int c = 0; c < NCELL; c++) begin
      // now and then the line skips cell 0 and keeps the old scalars
      if (c == 0 && $urandom_range(9) == 0) continue;
      send_item(MODE_CELL, 6'(c), rnd_cell(), acc, spd, fs, w, iw, c == NCELL - 1);
    end
  endtask

  // noise: any index, any mode, occasional early compute
  task automatic send_noise();
    mode_e md;
    md = $urandom_range(1) ? MODE_CELL : MODE_FACE;
    send_item(md, 6'($urandom_range(0, 63)), $urandom(), $urandom(), $urandom(), $urandom(),
              31'($urandom()), 31'($urandom()), $urandom_range(11) == 0);
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // setup: every face and cell written once, default registers
    for (int f = 0; f <= NCELL; f++)
      send_item(MODE_FACE, 6'(f), rnd_q(2 * ONE), 0, 0, 0, '0, '0, 1'b0);
    for (int c = 0; c < NCELL; c++)
      send_item(MODE_CELL, 6'(c), $urandom_range(0, 8 * ONE), 2 * ONE, ONE, ONE,
                31'(ONE), 31'(ONE), c == NCELL - 1);
    drain();
    write_reg(CFG_DT, ONE);
    write_reg(CFG_FLOOR, 0);

    // directed: ignored writes, dropped cells, extremes, early compute
    send_item(MODE_FACE, 6'd33, 32'h7FFF_FFFF, 0, 0, 0, '0, '0, 1'b1);
    send_item(MODE_FACE, 6'd63, 32'h8000_0000, 0, 0, 0, '0, '0, 1'b0);
    send_item(MODE_FACE, 6'd0, 32'h8000_0000, 0, 0, 0, '0, '0, 1'b1);
    send_item(MODE_FACE, 6'(NCELL), 32'h7FFF_FFFF, 0, 0, 0, '0, '0, 1'b0);
    send_item(MODE_FACE, 6'd5, 32'h7FFF_FFFF, 0, 0, 0, '0, '0, 1'b0);
    send_item(MODE_FACE, 6'd6, 32'h8000_0000, 0, 0, 0, '0, '0, 1'b0);
    send_item(MODE_CELL, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_item(MODE_CELL, 6'd1, 32'h8000_0000, 0, 0, 0, '0, '0, 1'b0);
    send_item(MODE_CELL, 6'd5, 0, 0, 0, 0, '0, '0, 1'b1);
    send_item(MODE_CELL, 6'd40, 32'h1234_5678, 0, 0, 0, '0, '0, 1'b1);
    send_item(MODE_CELL, 6'd63, -1, 0, 0, 0, '0, '0, 1'b0);
    send_item(MODE_CELL, 6'd0, ONE, 32'h8000_0000, 0, 32'h8000_0000, '0, '0, 1'b1);
    send_item(MODE_CELL, 6'(NCELL - 1), 0, 0, 0, 0, '0, '0, 1'b1);
    drain();
    write_reg(CFG_DT, 32'h7FFF_FFFF);
    write_reg(CFG_FLOOR, 32'h7FFF_FFFF);
    send_item(MODE_CELL, 6'd0, 8 * ONE, -ONE, 32'h7FFF_FFFF, ONE, 31'(2 * ONE), 31'(ONE),
              1'b1);
    drain();

    // random phases with the registers changed in between
    target = items_sent + 480;
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 26 : (ph == 1) ? 53 : 0;
      rcv_idle = (ph == 0) ? 53 : (ph == 1) ? 26 : 0;
      case (ph)
        0: begin
          write_reg(CFG_DT, ONE / 4);
          write_reg(CFG_FLOOR, 32'(FLOOR_RESET));
        end
        1: begin
          write_reg(CFG_DT, $urandom_range(0, 2 * ONE));
          write_reg(CFG_FLOOR, 1);
        end
        default: begin
          write_reg(CFG_DT, 0);
          write_reg(CFG_FLOOR, $urandom_range(1, 8 * ONE));
        end
      endcase
      while (items_sent < target - (2 - ph) * 160) begin
        if ($urandom_range(9) < 7) send_line();
        else send_noise();
      end
      drain();
    end

    drain();
    repeat (200) @(negedge clk_i);
    $display("ran %0d input transfers, %0d line updates, %0d register writes",
             items_sent, board.lines, cfg_writes);
    $display("checked %0d result transfers, %0d mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("limited_flux_line_advection_top_tb OK");
    end else begin
      $display("limited_flux_line_advection_top_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
